// ----- design/plil_pkg.sv -----
// Package for the positional list unit: record, command and result types,
// op codes and field widths. Used by every module of the block.
// No dependencies.
package plil_pkg;

	localparam int DEPTH_DEF = 1024;
	localparam int LOC_W     = 10;
	localparam int COUNT_W   = 11;
	localparam int OP_W      = 3;

	localparam logic [7:0] EMPTY_TAG = 8'd88; // 'X'

	localparam logic [OP_W-1:0] OP_INS_BEFORE = 3'd0;
	localparam logic [OP_W-1:0] OP_INS_AFTER  = 3'd1;
	localparam logic [OP_W-1:0] OP_SET        = 3'd2;
	localparam logic [OP_W-1:0] OP_REMOVE     = 3'd3;
	localparam logic [OP_W-1:0] OP_READ       = 3'd4;

	typedef struct packed {
		logic [63:0]        value;
		logic [7:0]         tag;
		logic signed [31:0] key;
	} rec_t;

	typedef struct packed {
		logic [OP_W-1:0]  operation;
		logic [LOC_W-1:0] location;
		rec_t             rec;
	} cmd_t;

	typedef struct packed {
		logic               is_empty;
		logic [COUNT_W-1:0] count;
		rec_t               rec;
		logic               ok;
	} res_t;

endpackage

// ----- design/plil_ram.sv -----
// Record store of the positional list: one write port, one read port,
// read data registered. Depends on plil_pkg.
module plil_ram import plil_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  rec_t          wdata,
	input  logic [AW-1:0] raddr,
	output rec_t          rdata
);

	rec_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- design/plil_seq.sv -----
// Sequencer of the positional list: decodes one command, shifts records
// through the RAM one entry a cycle and builds the result.
// Depends on plil_pkg and plil_ram.
module plil_seq import plil_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  cmd_t in_cmd,
	output logic res_valid,
	input  logic res_ready,
	output res_t res
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int PW = (CW > LOC_W) ? CW : LOC_W + 1;
	localparam int OW = (CW > COUNT_W) ? CW : COUNT_W;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DISP = 3'd1;
	localparam logic [2:0] S_UP   = 3'd2;
	localparam logic [2:0] S_WR   = 3'd3;
	localparam logic [2:0] S_RD   = 3'd4;
	localparam logic [2:0] S_CAP  = 3'd5;
	localparam logic [2:0] S_DOWN = 3'd6;
	localparam logic [2:0] S_DONE = 3'd7;

	logic [2:0]    state_q;
	logic [CW-1:0] count_q;
	cmd_t          cmd_q;
	logic [CW-1:0] pos_q;
	logic [CW-1:0] idx_q;
	logic          ok_q;
	rec_t          rec_q;
	logic          pend_s1;
	logic [AW-1:0] wa_s1;

	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	rec_t          ram_wdata;
	logic [AW-1:0] ram_raddr;
	rec_t          ram_rdata;

	logic [PW-1:0] loc_w;
	logic [PW-1:0] cnt_w;
	logic [PW-1:0] pos_w;
	logic          full;
	logic          in_range;
	logic          ok_c;
	logic [CW-1:0] idx_m1;
	logic [CW:0]   idx_p1;
	logic          down_more;
	logic [OW-1:0] cnt_o;

	plil_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// position checks, done wide enough for both location and count
	assign loc_w    = PW'(cmd_q.location);
	assign cnt_w    = PW'(count_q);
	assign full     = (count_q == CW'(DEPTH));
	assign in_range = (loc_w < cnt_w);
	assign pos_w    = (cmd_q.operation == OP_INS_AFTER) ? loc_w + PW'(1) : loc_w;

	always_comb begin
		case (cmd_q.operation)
			OP_INS_BEFORE: ok_c = !full && (in_range || (loc_w == '0));
			OP_INS_AFTER:  ok_c = !full && in_range;
			OP_SET:        ok_c = in_range;
			OP_REMOVE:     ok_c = in_range;
			OP_READ:       ok_c = in_range;
			default:       ok_c = 1'b0;
		endcase
	end

	assign idx_m1    = idx_q - CW'(1);
	assign idx_p1    = {1'b0, idx_q} + (CW+1)'(1);
	assign down_more = idx_p1 < {1'b0, count_q};

	// RAM port steering; a read issued last cycle is written back now
	always_comb begin
		ram_we    = pend_s1;
		ram_waddr = wa_s1;
		ram_wdata = ram_rdata;
		ram_raddr = idx_q[AW-1:0];
		case (state_q)
			S_UP:    ram_raddr = idx_m1[AW-1:0];
			S_DOWN:  ram_raddr = idx_p1[AW-1:0];
			S_RD:    ram_raddr = pos_q[AW-1:0];
			S_WR: begin
				ram_we    = 1'b1;
				ram_waddr = pos_q[AW-1:0];
				ram_wdata = cmd_q.rec;
			end
			default: ram_raddr = idx_q[AW-1:0];
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			pend_s1 <= 1'b0;
		end else begin
			pend_s1 <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_DISP;
					end
				end
				S_DISP: begin
					if (!ok_c) begin
						state_q <= S_DONE;
					end else if (cmd_q.operation == OP_SET) begin
						state_q <= S_WR;
					end else if (cmd_q.operation == OP_REMOVE ||
							cmd_q.operation == OP_READ) begin
						state_q <= S_RD;
					end else begin
						state_q <= S_UP;
					end
				end
				S_UP: begin
					if (idx_q != pos_q) begin
						pend_s1 <= 1'b1;
					end else begin
						state_q <= S_WR;
					end
				end
				S_WR: begin
					if (cmd_q.operation != OP_SET) begin
						count_q <= count_q + CW'(1);
					end
					state_q <= S_DONE;
				end
				S_RD:   state_q <= S_CAP;
				S_CAP: begin
					state_q <= (cmd_q.operation == OP_REMOVE) ? S_DOWN : S_DONE;
				end
				S_DOWN: begin
					if (down_more) begin
						pend_s1 <= 1'b1;
					end else begin
						count_q <= count_q - CW'(1);
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd_q <= in_cmd;
				end
			end
			S_DISP: begin
				pos_q <= pos_w[CW-1:0];
				idx_q <= count_q;
				ok_q  <= ok_c;
				if (ok_c) begin
					rec_q <= cmd_q.rec;
				end else begin
					rec_q <= '{value: '0, tag: EMPTY_TAG, key: '0};
				end
			end
			S_UP: begin
				if (idx_q != pos_q) begin
					wa_s1 <= idx_q[AW-1:0];
					idx_q <= idx_m1;
				end
			end
			S_CAP: begin
				rec_q <= ram_rdata;
				idx_q <= pos_q;
			end
			S_DOWN: begin
				if (down_more) begin
					wa_s1 <= idx_q[AW-1:0];
					idx_q <= idx_p1[CW-1:0];
				end
			end
			default: wa_s1 <= wa_s1;
		endcase
	end

	assign cnt_o        = OW'(count_q);
	assign in_ready     = (state_q == S_IDLE);
	assign res_valid    = (state_q == S_DONE);
	assign res.ok       = ok_q;
	assign res.rec      = rec_q;
	assign res.count    = cnt_o[COUNT_W-1:0];
	assign res.is_empty = (count_q == '0);

endmodule

// ----- design/positional_list_insert_remove_unit.sv -----
// Positional list unit: an ordered list of up to DEPTH records (key, tag,
// value) held in one synchronous RAM.
// Input stream s_axis carries one command item: insert before, insert
// after, set, remove or read at a position. Output stream m_axis carries
// one result item per command: ok flag, record involved, count, empty flag.
// A rejected command returns key 0, tag 'X', value 0 and the unchanged count.
// Steps from input accept to result valid:
//   rejected commands: decode only; set: decode, write; read: decode,
//   RAM read, capture; inserts: decode, entries from the end down to the
//   position where the new record lands move up one per cycle, then write;
//   remove: decode, read, capture, entries above it move down one per cycle.
// One command is processed at a time; the next is taken in the cycle after
// the result leaves the sequencer.
// The worst case is a remove at the head of a full list, set by the single
// RAM read port doing one entry move per cycle.
// The result sits in an output register, so the next command is taken
// while a finished result still waits; a stalled receiver holds the result
// and, once the sequencer finishes the next command, stalls input.
// Reset empties the list at once; RAM contents are not cleared.
// Depends on plil_pkg, plil_seq and plil_ram.
module positional_list_insert_remove_unit import plil_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// operation[2:0], location[12:3], entry_key[44:13], entry_tag[52:45],
	// entry_value[116:53], zero fill [119:117]
	input  logic [119:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// ok[0], out_key[32:1], out_tag[40:33], out_value[104:41],
	// count[115:105], is_empty[116], zero fill [119:117]
	output logic [119:0] m_axis_tdata
);

	cmd_t in_cmd;
	res_t res;
	logic res_valid;
	logic res_ready;
	logic m_valid_q;
	res_t m_res_q;

	assign in_cmd.operation = s_axis_tdata[2:0];
	assign in_cmd.location  = s_axis_tdata[12:3];
	assign in_cmd.rec.key   = s_axis_tdata[44:13];
	assign in_cmd.rec.tag   = s_axis_tdata[52:45];
	assign in_cmd.rec.value = s_axis_tdata[116:53];

	plil_seq #(.DEPTH(DEPTH)) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_cmd    (in_cmd),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	assign res_ready = !m_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (res_ready) begin
			m_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			m_res_q <= res;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {3'b000, m_res_q};

	// a rejected item always carries the empty record
	a_reject_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q && !m_res_q.ok |->
		m_res_q.rec.key == '0 && m_res_q.rec.tag == EMPTY_TAG && m_res_q.rec.value == '0)
		else $error("rejected item with non-empty record");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q |-> m_res_q.is_empty == (m_res_q.count == '0))
		else $error("empty flag disagrees with count");

	// sequencer idle means no result is pending inside it
	a_idle_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> !res_valid)
		else $error("sequencer ready while holding a result");

	// count moves by at most one between consecutive results
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_ready && m_valid_q |->
		res.count == m_res_q.count || res.count == m_res_q.count + 11'd1 ||
		res.count == m_res_q.count - 11'd1)
		else $error("count jumped by more than one");

endmodule

// ----- tb/list_checker.sv -----
// Checker for the positional list unit: watches both streams, keeps its own
// copy of the list, predicts each result item and compares it field by field.
// Depends on plil_pkg.
`timescale 1ns / 1ps

module list_checker import plil_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	input  logic         s_axis_tready,
	// operation[2:0], location[12:3], entry_key[44:13], entry_tag[52:45],
	// entry_value[116:53], zero fill [119:117]
	input  logic [119:0] s_axis_tdata,
	input  logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// ok[0], out_key[32:1], out_tag[40:33], out_value[104:41],
	// count[115:105], is_empty[116], zero fill [119:117]
	input  logic [119:0] m_axis_tdata,
	output int           failures,
	output int           outstanding
);

	rec_t        list_store [DEPTH];
	int unsigned list_len = 0;
	res_t        pending_results [$];
	res_t        got, want;

	initial begin
		failures = 0;
		outstanding = 0;
	end

	// Applies one command to the list copy and returns the result item it gives.
	function automatic res_t run_command(input logic [OP_W-1:0] op,
			input logic [LOC_W-1:0] loc, input rec_t rec);
		res_t        r;
		int unsigned pos;
		int unsigned loc_u;
		logic        done;
		done = 1'b0;
		pos = 0;
		loc_u = 32'(loc);
		r.rec.key = '0;
		r.rec.tag = EMPTY_TAG;
		r.rec.value = '0;
		case (op)
			OP_INS_BEFORE, OP_INS_AFTER: begin
				if (list_len < DEPTH) begin
					if (op == OP_INS_BEFORE && (loc_u < list_len || loc_u == 0)) begin
						pos = loc_u;
						done = 1'b1;
					end else if (op == OP_INS_AFTER && loc_u < list_len) begin
						pos = loc_u + 1;
						done = 1'b1;
					end
				end
			end
			OP_SET, OP_REMOVE, OP_READ: begin
				if (loc_u < list_len) begin
					pos = loc_u;
					done = 1'b1;
				end
			end
			default: ;
		endcase
		if (done) begin
			if (op == OP_INS_BEFORE || op == OP_INS_AFTER) begin
				for (int unsigned i = list_len; i > pos; i--)
					list_store[i] = list_store[i - 1];
				list_len++;
			end
			if (op == OP_INS_BEFORE || op == OP_INS_AFTER || op == OP_SET)
				list_store[pos] = rec;
			r.rec = list_store[pos];
			if (op == OP_REMOVE) begin
				for (int unsigned i = pos; i + 1 < list_len; i++)
					list_store[i] = list_store[i + 1];
				list_len--;
			end
		end
		r.ok = done;
		r.count = list_len[COUNT_W-1:0];
		r.is_empty = (list_len == 0);
		return r;
	endfunction

	task automatic compare_field(input string field, input logic [63:0] expected,
			input logic [63:0] actual);
		if (expected !== actual) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, field,
				expected, actual);
			failures++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = m_axis_tdata[116:0];
				if (pending_results.size() == 0) begin
					$display("%0t: result item with none expected, actual %h", $time,
						m_axis_tdata);
					failures++;
				end else begin
					want = pending_results.pop_front();
					compare_field("ok", 64'(want.ok), 64'(got.ok));
					compare_field("out_key", 64'(want.rec.key), 64'(got.rec.key));
					compare_field("out_tag", 64'(want.rec.tag), 64'(got.rec.tag));
					compare_field("out_value", want.rec.value, got.rec.value);
					compare_field("count", 64'(want.count), 64'(got.count));
					compare_field("is_empty", 64'(want.is_empty), 64'(got.is_empty));
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				pending_results.push_back(run_command(s_axis_tdata[2:0],
					s_axis_tdata[12:3], s_axis_tdata[116:13]));
			outstanding = pending_results.size();
		end
	end

endmodule

// ----- tb/testbench.sv -----
// Top of the positional list unit testbench: clock, reset, command stimulus
// and receiver stalls; checking is done in list_checker.
// Depends on plil_pkg, list_checker and positional_list_insert_remove_unit.
`timescale 1ns / 1ps

module testbench;
	import plil_pkg::*;

	localparam int LIST_DEPTH = DEPTH_DEF;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [119:0] s_axis_tdata = '0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [119:0] m_axis_tdata;
	int           failures;
	int           outstanding;

	logic        hold_off_req = 1'b0;
	int          burst_left = 0;
	// length the list will have once every command sent so far has been done
	int unsigned list_len = 0;

	always #1 clk = ~clk;

	positional_list_insert_remove_unit #(.DEPTH(LIST_DEPTH)) i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	list_checker #(.DEPTH(LIST_DEPTH)) i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.failures      (failures),
		.outstanding   (outstanding)
	);

	function automatic rec_t random_record();
		rec_t r;
		r.key = $urandom;
		r.tag = 8'($urandom_range(0, 255));
		r.value = {$urandom, $urandom};
		case ($urandom_range(0, 15))
			0: r.key = 32'sh8000_0000;
			1: r.key = 32'sh7fff_ffff;
			2: r.value = '1;
			3: r.value = '0;
			4: r.tag = 8'h00;
			5: r.tag = 8'hff;
			default: ;
		endcase
		return r;
	endfunction

	// Offers one command item and returns at the edge where it is taken.
	task automatic push_command(input logic [OP_W-1:0] op, input logic [LOC_W-1:0] loc,
			input rec_t rec);
		int unsigned loc_u;
		loc_u = 32'(loc);
		if (burst_left == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80)
				: $urandom_range(1, 12);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {3'b000, rec, loc, op};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		burst_left--;
		case (op)
			OP_INS_BEFORE: if (list_len < LIST_DEPTH && (loc_u < list_len || loc_u == 0))
				list_len++;
			OP_INS_AFTER: if (list_len < LIST_DEPTH && loc_u < list_len) list_len++;
			OP_REMOVE: if (loc_u < list_len) list_len--;
			default: ;
		endcase
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	// receiver: stall pattern changes at random spans, one long hold-off
	initial begin
		int  span;
		int  stall_mode;
		bit  hold_done;
		span = 0;
		stall_mode = 0;
		hold_done = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off_req && !hold_done) begin
				hold_done = 1'b1;
				m_axis_tready <= 1'b0;
				repeat (400) @(posedge clk);
			end
			if (span == 0) begin
				stall_mode = $urandom_range(0, 3);
				span = $urandom_range(20, 120);
			end
			span--;
			case (stall_mode)
				0: m_axis_tready <= 1'b1;
				1: m_axis_tready <= ($urandom_range(0, 3) != 0);
				2: m_axis_tready <= ($urandom_range(0, 3) == 0);
				default: m_axis_tready <= span[2];
			endcase
		end
	end

	initial begin
		logic [OP_W-1:0]  op;
		logic [LOC_W-1:0] loc;
		int unsigned      target;
		int unsigned      roll;
		bit               grow;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty list: everything but insert before 0 is turned away; then edge records, out-of-range reads, unused op codes
		push_command(OP_READ, 10'd0, random_record());
		push_command(OP_REMOVE, 10'd0, random_record());
		push_command(OP_SET, 10'd0, random_record());
		push_command(OP_INS_AFTER, 10'd0, random_record());
		push_command(OP_INS_BEFORE, 10'h3ff, random_record());
		push_command(OP_INS_BEFORE, 10'd0, '{value: '0, tag: 8'h00, key: 32'sh8000_0000});
		push_command(OP_INS_AFTER, 10'd0, '{value: '1, tag: 8'hff, key: 32'sh7fff_ffff});
		push_command(OP_INS_BEFORE, 10'd1, '{value: '1, tag: EMPTY_TAG, key: -32'sd1});
		push_command(OP_INS_BEFORE, 10'd0, '{value: 64'h1, tag: 8'h01, key: 32'sd0});
		push_command(OP_READ, 10'd3, random_record());
		push_command(OP_READ, 10'd4, random_record());
		push_command(OP_SET, 10'd2, random_record());
		push_command(3'd5, 10'd0, random_record());
		push_command(3'd6, 10'd1, random_record());
		push_command(3'd7, 10'h3ff, random_record());
		push_command(OP_READ, 10'h3ff, random_record());
		push_command(OP_REMOVE, 10'd0, random_record());
		push_command(OP_REMOVE, 10'd2, random_record());
		push_command(OP_REMOVE, 10'd1, random_record());
		push_command(OP_READ, 10'd0, random_record());
		push_command(OP_REMOVE, 10'd0, random_record());
		push_command(OP_READ, 10'd0, random_record());
		wait_drained();

		// random mix around a moving target length; output held off early on
		hold_off_req = 1'b1;
		target = 2;
		for (int n = 0; n < 555; n++) begin
			if (n % 60 == 0)
				case ($urandom_range(0, 4))
					0: target = 2;
					1: target = 8;
					2: target = 24;
					3: target = 60;
					default: target = 150;
				endcase
			if ($urandom_range(0, 99) < 12) begin
				op = OP_W'($urandom_range(0, 7));
				loc = LOC_W'($urandom_range(0, 1023));
			end else begin
				roll = $urandom_range(0, 99);
				grow = (list_len < target);
				if (roll < 55) begin
					if ((roll < 40) == grow)
						op = $urandom_range(0, 1) ? OP_INS_BEFORE : OP_INS_AFTER;
					else
						op = OP_REMOVE;
				end else if (roll < 78) begin
					op = OP_SET;
				end else begin
					op = OP_READ;
				end
				if (list_len == 0)
					loc = '0;
				else
					case ($urandom_range(0, 9))
						0: loc = LOC_W'((list_len < LIST_DEPTH) ? list_len : list_len - 1);
						1: loc = LOC_W'(list_len - 1);
						2: loc = '0;
						default: loc = LOC_W'($urandom_range(0, list_len - 1));
					endcase
			end
			push_command(op, loc, random_record());
		end

		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (20) @(posedge clk);
		if (failures == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		#40_000_000;
		$display("Some tests failed");
		$finish;
	end

endmodule
